[rtl/core/mm_pkg.sv]
// Package for the fixed-point matrix multiply block.
// Holds op codes, register indexes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int IDX_W    = 3;   // row/column index fields
    localparam int DIM_W    = 4;   // dimension registers
    localparam int ELEM_W   = 16;  // element field (Q8.8)
    localparam int OUT_W    = 35;  // result value (Q19.16)
    localparam int REG_ADDR_W = 4;

    typedef enum logic [1:0] {
        OP_WR_LEFT  = 2'd0,
        OP_WR_RIGHT = 2'd1,
        OP_RUN      = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ROWS_M  = 2'd0,
        REG_INNER_K = 2'd1,
        REG_COLS_N  = 2'd2,
        REG_UNUSED  = 2'd3
    } reg_idx_t;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_ISSUE = 1'b1
    } state_t;

    typedef struct packed {
        logic               wr_left;
        logic               wr_right;
        logic [IDX_W-1:0]   wr_row;
        logic [IDX_W-1:0]   wr_col;
        logic [ELEM_W-1:0]  wr_value;
        logic               issue;
        logic               first;
        logic               last_t;
        logic               last_elem;
        logic [IDX_W-1:0]   i;
        logic [IDX_W-1:0]   j;
        logic [IDX_W-1:0]   t;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_busy;
    } status_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input int unsigned max_dim);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (int'(r) > int'(max_dim))
            d = DIM_W'(max_dim);
        else
            d = r;
        return d;
    endfunction

endpackage

[rtl/core/mm_ctrl.sv]
// Controller for the matrix multiply: load decode and the i/j/t run sequencer.
// Depends on mm_pkg; drives the datapath through cmd_t, watches status_t.
`timescale 1ns / 1ps

module mm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_op,
    input  logic [mm_pkg::IDX_W-1:0]  in_row,
    input  logic [mm_pkg::IDX_W-1:0]  in_col,
    input  logic [mm_pkg::ELEM_W-1:0] in_value,
    input  logic [mm_pkg::DIM_W-1:0]  rows_m,
    input  logic [mm_pkg::DIM_W-1:0]  inner_k,
    input  logic [mm_pkg::DIM_W-1:0]  cols_n,
    input  mm_pkg::status_t        sts,
    output mm_pkg::cmd_t           cmd
);
    import mm_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [DIM_W-1:0]  m_eff, k_eff, n_eff;
    logic              take;
    logic              can_go;
    logic              t_end, j_end, i_end;

    assign m_eff = eff_dim(rows_m, MAX_DIM);
    assign k_eff = eff_dim(inner_k, MAX_DIM);
    assign n_eff = eff_dim(cols_n, MAX_DIM);

    assign t_end = (DIM_W'(t_reg) == k_eff - DIM_W'(1));
    assign j_end = (DIM_W'(j_reg) == n_eff - DIM_W'(1));
    assign i_end = (DIM_W'(i_reg) == m_eff - DIM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        in_ready     = 1'b0;
        take         = 1'b0;
        can_go       = 1'b0;
        cmd          = '0;
        cmd.wr_row   = in_row;
        cmd.wr_col   = in_col;
        cmd.wr_value = in_value;
        cmd.i        = i_reg;
        cmd.j        = j_reg;
        cmd.t        = t_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                take     = in_valid;
                if (take)
                begin
                    case (op_t'(in_op))
                        OP_WR_LEFT:
                        begin
                            cmd.wr_left = (DIM_W'(in_row) < m_eff) &&
                                          (DIM_W'(in_col) < k_eff);
                        end
                        OP_WR_RIGHT:
                        begin
                            cmd.wr_right = (DIM_W'(in_row) < k_eff) &&
                                           (DIM_W'(in_col) < n_eff);
                        end
                        OP_RUN:
                        begin
                            state_next = ST_ISSUE;
                            i_next     = '0;
                            j_next     = '0;
                            t_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                // a new element starts only on an empty pipe and a free output
                can_go = (t_reg != '0) || (!sts.pipe_busy && !sts.out_busy);
                if (can_go)
                begin
                    cmd.issue     = 1'b1;
                    cmd.first     = (t_reg == '0);
                    cmd.last_t    = t_end;
                    cmd.last_elem = i_end && j_end && t_end;
                    if (t_end)
                    begin
                        t_next = '0;
                        if (j_end)
                        begin
                            j_next = '0;
                            if (i_end)
                            begin
                                i_next     = '0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                i_next = i_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        t_next = t_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/mm_dp.sv]
// Datapath for the matrix multiply: element memories, multiply-accumulate pipe, output register.
// Depends on mm_pkg; commanded by mm_ctrl.
`timescale 1ns / 1ps

module mm_dp #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mm_pkg::cmd_t              cmd,
    output mm_pkg::status_t           sts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mm_pkg::IDX_W-1:0]  out_row,
    output logic [mm_pkg::IDX_W-1:0]  out_col,
    output logic [mm_pkg::OUT_W-1:0]  out_value,
    output logic                      out_last
);
    import mm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * DATA_WIDTH;

    typedef struct packed {
        logic             first;
        logic             last_t;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    logic [DATA_WIDTH-1:0] left_mem  [DEPTH];
    logic [DATA_WIDTH-1:0] right_mem [DEPTH];

    logic [ADDR_W-1:0]        waddr, left_raddr, right_raddr;
    logic signed [DATA_WIDTH-1:0] wr_elem;
    logic signed [DATA_WIDTH-1:0] left_rd_reg, right_rd_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [OUT_W-1:0]  acc_reg, acc_next, acc_base, prod_ext;
    logic                     s1_valid_reg, s2_valid_reg;
    tag_t                     s1_tag_reg, s2_tag_reg, tag_in;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic [OUT_W-1:0]         out_value_reg;
    logic                     out_last_reg;
    logic                     load_out;

    assign wr_elem     = DATA_WIDTH'(signed'(cmd.wr_value));
    assign waddr       = ADDR_W'(int'(cmd.wr_row) * MAX_DIM + int'(cmd.wr_col));
    assign left_raddr  = ADDR_W'(int'(cmd.i) * MAX_DIM + int'(cmd.t));
    assign right_raddr = ADDR_W'(int'(cmd.t) * MAX_DIM + int'(cmd.j));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_left)
            left_mem[waddr] <= wr_elem;
        if (cmd.wr_right)
            right_mem[waddr] <= wr_elem;
        left_rd_reg  <= left_mem[left_raddr];
        right_rd_reg <= right_mem[right_raddr];
    end

    assign tag_in.first     = cmd.first;
    assign tag_in.last_t    = cmd.last_t;
    assign tag_in.last_elem = cmd.last_elem;
    assign tag_in.row       = cmd.i;
    assign tag_in.col       = cmd.j;

    assign prod_next = left_rd_reg * right_rd_reg;
    assign prod_ext  = OUT_W'(prod_reg);
    assign acc_base  = s2_tag_reg.first ? '0 : acc_reg;
    assign acc_next  = acc_base + prod_ext;
    assign load_out  = s2_valid_reg && s2_tag_reg.last_t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= tag_in;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= prod_next;
        if (s2_valid_reg)
            acc_reg <= acc_next;
        if (load_out)
        begin
            out_row_reg   <= s2_tag_reg.row;
            out_col_reg   <= s2_tag_reg.col;
            out_value_reg <= acc_next;
            out_last_reg  <= s2_tag_reg.last_elem;
        end
    end

    assign sts.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // a finished sum never lands on a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten");

    // each element starts on an empty pipe
    a_first_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.first) |-> !s1_valid_reg && !s2_valid_reg)
        else $error("element started with pipe busy");

    // the last element of a run always closes its own dot product
    a_last_elem: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_tag_reg.last_elem) |-> s2_tag_reg.last_t)
        else $error("last element without last term");

    // no element store write while the pipe is fed
    a_no_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !cmd.wr_left && !cmd.wr_right)
        else $error("store write during run");

endmodule

[rtl/core/matrix_multiply.sv]
// Top level of the fixed-point matrix multiply C = A x B (Q8.8 in, Q19.16 out).
// Depends on mm_pkg, mm_ctrl and mm_dp.
//
//   channel   | dir | handshake         | contents
//   s_axis    | in  | s_tvalid/s_tready | op, row_index, col_index, elem_value
//   m_axis    | out | m_tvalid/m_tready | out_row, out_col, out_value, last (tlast)
//   apb       | in  | psel/penable      | rows_m @0x0, inner_k @0x4, cols_n @0x8
//
// One shared multiply-accumulate unit reads one A/B pair a cycle within a dot
// product; the pipe drains before the next result element starts. s_tready is low
// while a run is sequenced. Reset clears the control state and sets the dimensions
// to 8; the element stores are not cleared. A stalled result holds the sequencer
// before the next element starts.
`timescale 1ns / 1ps

module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[1:0], row_index[4:2], col_index[7:5], elem_value[23:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[40:6], zero[47:41]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mm_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mm_pkg::*;

    logic [DIM_W-1:0] rows_m_reg, inner_k_reg, cols_n_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    cmd_t             cmd;
    status_t          sts;
    logic [IDX_W-1:0] out_row, out_col;
    logic [OUT_W-1:0] out_value;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= DIM_W'(8);
            inner_k_reg <= DIM_W'(8);
            cols_n_reg  <= DIM_W'(8);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ROWS_M:  rows_m_reg  <= pwdata[DIM_W-1:0];
                REG_INNER_K: inner_k_reg <= pwdata[DIM_W-1:0];
                REG_COLS_N:  cols_n_reg  <= pwdata[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROWS_M:  prdata = 32'(rows_m_reg);
            REG_INNER_K: prdata = 32'(inner_k_reg);
            REG_COLS_N:  prdata = 32'(cols_n_reg);
            default:     prdata = '0;
        endcase
    end

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tdata[1:0]),
        .in_row   (s_tdata[4:2]),
        .in_col   (s_tdata[7:5]),
        .in_value (s_tdata[23:8]),
        .rows_m   (rows_m_reg),
        .inner_k  (inner_k_reg),
        .cols_n   (cols_n_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    mm_dp #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, out_value, out_col, out_row};

endmodule

[tb/sv/mm_checker.sv]
// Result checker for matrix_multiply: snoops the input, result and register channels,
// keeps its own copy of both element stores and the dimensions, and compares every result.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // op[1:0], row_index[4:2], col_index[7:5], elem_value[23:8]
    input  logic [23:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // out_row[2:0], out_col[5:3], out_value[40:6], zero[47:41]
    input  logic [47:0]                   m_tdata,
    input  logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mm_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            outstanding,
    output int                            runs_seen,
    output int                            elems_checked
);
    import mm_pkg::*;

    localparam int MAX_DIM = 8;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [34:0] value;
        logic        last;
    } c_elem_t;

    logic signed [15:0] left_elems  [MAX_DIM][MAX_DIM];
    logic signed [15:0] right_elems [MAX_DIM][MAX_DIM];
    logic [3:0]         rows_m;
    logic [3:0]         inner_k;
    logic [3:0]         cols_n;
    c_elem_t            c_elems_due [$];
    int                 mismatches;
    int                 runs;
    int                 checked;

    function automatic int active_dim(input logic [3:0] r);
        if (r == 4'd0)
            return 1;
        if (r > 4'(MAX_DIM))
            return MAX_DIM;
        return int'(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        c_elem_t    got;
        c_elem_t    want;
        longint     acc;
        int         m_act;
        int         k_act;
        int         n_act;
        logic [2:0] w_row;
        logic [2:0] w_col;
        if (!rst_n)
        begin
            rows_m  = 4'd8;
            inner_k = 4'd8;
            cols_n  = 4'd8;
            c_elems_due.delete();
            mismatches = 0;
            runs       = 0;
            checked    = 0;
            fail_count    <= 0;
            outstanding   <= 0;
            runs_seen     <= 0;
            elems_checked <= 0;
        end
        else
        begin
            m_act = active_dim(rows_m);
            k_act = active_dim(inner_k);
            n_act = active_dim(cols_n);

            // result side first: a result never belongs to a run accepted at the same edge
            if (m_tvalid && m_tready)
            begin
                got.row   = m_tdata[2:0];
                got.col   = m_tdata[5:3];
                got.value = m_tdata[40:6];
                got.last  = m_tlast;
                if (c_elems_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: result with nothing pending: row %0d col %0d %s",
                                 $time, got.row, got.col,
                                 $sformatf("value %0d last %b", $signed(got.value), got.last));
                end
                else
                begin
                    want = c_elems_due.pop_front();
                    checked++;
                    if (got != want || m_tdata[47:41] != '0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%t: result mismatch", $time);
                            $display("    expected row %0d col %0d value %0d last %b pad 0",
                                     want.row, want.col, $signed(want.value), want.last);
                            $display("    actual   row %0d col %0d value %0d last %b pad %h",
                                     got.row, got.col, $signed(got.value), got.last,
                                     m_tdata[47:41]);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                w_row = s_tdata[4:2];
                w_col = s_tdata[7:5];
                case (op_t'(s_tdata[1:0]))
                    OP_WR_LEFT:
                        if (w_row < m_act && w_col < k_act)
                            left_elems[w_row][w_col] = s_tdata[23:8];
                    OP_WR_RIGHT:
                        if (w_row < k_act && w_col < n_act)
                            right_elems[w_row][w_col] = s_tdata[23:8];
                    OP_RUN:
                    begin
                        for (int i = 0; i < m_act; i++)
                            for (int j = 0; j < n_act; j++)
                            begin
                                acc = 0;
                                for (int t = 0; t < k_act; t++)
                                    acc += longint'(left_elems[i][t]) *
                                           longint'(right_elems[t][j]);
                                want.row   = 3'(i);
                                want.col   = 3'(j);
                                want.value = acc[34:0];
                                want.last  = (i == m_act - 1) && (j == n_act - 1);
                                c_elems_due.push_back(want);
                            end
                        runs++;
                    end
                    default:
                        ;
                endcase
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_ROWS_M:  rows_m  = pwdata[3:0];
                    REG_INNER_K: inner_k = pwdata[3:0];
                    REG_COLS_N:  cols_n  = pwdata[3:0];
                    default:     ;
                endcase
            end

            fail_count    <= mismatches;
            outstanding   <= c_elems_due.size();
            runs_seen     <= runs;
            elems_checked <= checked;
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the matrix_multiply testbench: clock, reset, register writes, element loads and runs.
// Depends on mm_pkg, matrix_multiply and mm_checker, which does all the result checking.
`timescale 1ns / 1ps

module tb_top;
    import mm_pkg::*;

    localparam int ITEM_TARGET     = 470;
    localparam int SETTLE_CYCLES   = 32;
    localparam int HOLD_CYCLES     = 600;
    localparam int HOLD_AFTER_RUNS = 4;
    localparam int WATCHDOG_LIMIT  = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;   // op[1:0], row_index[4:2], col_index[7:5], elem_value[23:8]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;   // out_row[2:0], out_col[5:3], out_value[40:6], zero[47:41]
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int outstanding;
    int runs_seen;
    int elems_checked;
    int items_sent;
    int cfg_writes;
    int quiet_cycles;
    int rx_idle_pct = 79;
    int m_use = 8;
    int k_use = 8;
    int n_use = 8;
    bit hold_done;
    bit left_loaded  [8][8];
    bit right_loaded [8][8];

    matrix_multiply DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mm_checker CHK (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .runs_seen     (runs_seen),
        .elems_checked (elems_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, plus one long hold-off during a large run
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && m_tvalid && runs_seen >= HOLD_AFTER_RUNS)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic int dim_in_use(input logic [3:0] r);
        if (r == 4'd0)
            return 1;
        if (r > 4'd8)
            return 8;
        return int'(r);
    endfunction

    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 4'd0;
        if (r < 16)
            return 4'($urandom_range(15, 9));
        if (r < 22)
            return 4'd8;
        return 4'($urandom_range(4, 1));
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [3:0] m, input logic [3:0] k, input logic [3:0] n);
        drain_results();
        apb_write(REG_ROWS_M, m);
        apb_write(REG_INNER_K, k);
        apb_write(REG_COLS_N, n);
        m_use = dim_in_use(m);
        k_use = dim_in_use(k);
        n_use = dim_in_use(n);
    endtask

    task automatic send_item(input op_t op, input logic [2:0] row, input logic [2:0] col,
                             input logic [15:0] value);
        int tx_idle_pct;
        if (items_sent < ITEM_TARGET / 3)
        begin
            tx_idle_pct = 27;
            rx_idle_pct <= 79;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            tx_idle_pct = 79;
            rx_idle_pct <= 27;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
        end
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, col, row, op};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (op == OP_WR_LEFT && row < m_use && col < k_use)
            left_loaded[row][col] = 1'b1;
        if (op == OP_WR_RIGHT && row < k_use && col < n_use)
            right_loaded[row][col] = 1'b1;
    endtask

    // loads whatever the current dimensions would read but was never written, then runs
    task automatic complete_and_run(input bit max_fill);
        for (int i = 0; i < m_use; i++)
            for (int t = 0; t < k_use; t++)
                if (!left_loaded[i][t])
                    send_item(OP_WR_LEFT, 3'(i), 3'(t), max_fill ? 16'h8000 : rand_elem());
        for (int t = 0; t < k_use; t++)
            for (int j = 0; j < n_use; j++)
                if (!right_loaded[t][j])
                    send_item(OP_WR_RIGHT, 3'(t), 3'(j), max_fill ? 16'h8000 : rand_elem());
        send_item(OP_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int   nruns;
        int   nwr;
        op_t  noise_op;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme values, ignored writes, unused op, smallest and zero dimensions
        set_dims(4'd2, 4'd2, 4'd2);
        send_item(OP_WR_LEFT, 3'd0, 3'd0, 16'h8000);
        send_item(OP_WR_LEFT, 3'd0, 3'd1, 16'h7FFF);
        send_item(OP_WR_LEFT, 3'd1, 3'd0, 16'h0000);
        send_item(OP_WR_LEFT, 3'd1, 3'd1, 16'hFFFF);
        send_item(OP_WR_RIGHT, 3'd0, 3'd0, 16'h8000);
        send_item(OP_WR_RIGHT, 3'd0, 3'd1, 16'h0001);
        send_item(OP_WR_RIGHT, 3'd1, 3'd0, 16'h8000);
        send_item(OP_WR_RIGHT, 3'd1, 3'd1, 16'h7FFF);
        send_item(OP_WR_LEFT, 3'd7, 3'd7, 16'h1234);
        send_item(OP_WR_RIGHT, 3'd2, 3'd0, 16'h4321);
        send_item(OP_NONE, 3'd7, 3'd7, 16'hFFFF);
        complete_and_run(1'b0);
        set_dims(4'd1, 4'd1, 4'd1);
        complete_and_run(1'b0);
        set_dims(4'd0, 4'd0, 4'd0);
        send_item(OP_WR_RIGHT, 3'd0, 3'd1, 16'h5A5A);
        complete_and_run(1'b0);

        // random phases; the first fills full size with the most negative value and runs
        // twice, so the second run's loads queue up behind the long result hold-off
        for (int p = 0; items_sent < ITEM_TARGET; p++)
        begin
            if (p == 0)
                set_dims(4'd8, 4'd15, 4'd15);
            else
                set_dims(pick_dim(), pick_dim(), pick_dim());
            nruns = (p == 0) ? 2 : $urandom_range(2, 1);
            for (int r = 0; r < nruns; r++)
            begin
                nwr = (p == 0 && r == 0) ? 0 : $urandom_range(12, 1);
                repeat (nwr)
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        case ($urandom_range(2))
                            0:       noise_op = OP_WR_LEFT;
                            1:       noise_op = OP_WR_RIGHT;
                            default: noise_op = OP_NONE;
                        endcase
                        send_item(noise_op, 3'($urandom), 3'($urandom), rand_elem());
                    end
                    else if ($urandom_range(1) == 0)
                        send_item(OP_WR_LEFT, 3'($urandom_range(m_use - 1)),
                                  3'($urandom_range(k_use - 1)), rand_elem());
                    else
                        send_item(OP_WR_RIGHT, 3'($urandom_range(k_use - 1)),
                                  3'($urandom_range(n_use - 1)), rand_elem());
                end
                complete_and_run(p == 0);
            end
        end

        drain_results();
        $display("Run covered %0d input transfers in %0d multiplies and %0d register writes,",
                 items_sent, runs_seen, cfg_writes);
        $display("with %0d result transfers compared, dimension registers from 0 to 15.",
                 elems_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[matrix_multiply.f]
rtl/core/mm_pkg.sv
rtl/core/mm_ctrl.sv
rtl/core/mm_dp.sv
rtl/core/matrix_multiply.sv
tb/sv/mm_checker.sv
tb/sv/tb_top.sv
